### rtl/sector_cache_tag_manager_core_macros.svh
// assertion macros shared by the sector cache tag manager rtl
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef SECTOR_CACHE_TAG_MANAGER_CORE_MACROS_SVH
`define SECTOR_CACHE_TAG_MANAGER_CORE_MACROS_SVH

`ifndef ASSERT_OFF

`define SCTM_ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

`define SCTM_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`define SCTM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define SCTM_ASSERT_ALWAYS(label, clk, rst, expr)
`define SCTM_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define SCTM_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### rtl/sctm_pkg.sv
// shared types and defaults for the sector cache tag manager
// no dependencies
package sctm_pkg;

  localparam int DEFAULT_CACHE_SLOTS = 16;
  localparam int DEFAULT_SECTOR_BITS = 12;

  typedef enum logic [0:0] {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_t;

  typedef struct packed {
    logic hit;
    logic fill_needed;
  } status_t;

endpackage

### rtl/sctm_req_if.sv
// request channel: operation and sector number with valid/ready
// depends on sctm_pkg for the default width
interface sctm_req_if #(
  parameter int SECTOR_BITS = sctm_pkg::DEFAULT_SECTOR_BITS
);
  logic                   valid;
  logic                   ready;
  logic                   operation;
  logic [SECTOR_BITS-1:0] sector_number;

  modport source (output valid, output operation, output sector_number, input ready);
  modport sink   (input valid, input operation, input sector_number, output ready);
endinterface

### rtl/sctm_resp_if.sv
// response channel: hit, slot and fill request with valid/ready
// depends on sctm_pkg for the default slot count
interface sctm_resp_if #(
  parameter int CACHE_SLOTS = sctm_pkg::DEFAULT_CACHE_SLOTS,
  parameter int SLOT_W      = $clog2(CACHE_SLOTS)
);
  logic              valid;
  logic              ready;
  logic              hit;
  logic [SLOT_W-1:0] slot;
  logic              fill_needed;

  modport source (output valid, output hit, output slot, output fill_needed, input ready);
  modport sink   (input valid, input hit, input slot, input fill_needed, output ready);
endinterface

### rtl/sctm_tag_store.sv
// tag registers, valid bits, round-robin pointer and parallel compare
// depends on sctm_pkg and the macro header
`include "sector_cache_tag_manager_core_macros.svh"

module sctm_tag_store #(
  parameter int CACHE_SLOTS = sctm_pkg::DEFAULT_CACHE_SLOTS,
  parameter int SECTOR_BITS = sctm_pkg::DEFAULT_SECTOR_BITS,
  parameter int SLOT_W      = $clog2(CACHE_SLOTS)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   commit,
  input  logic                   operation,
  input  logic [SECTOR_BITS-1:0] sector_number,
  output sctm_pkg::status_t      status,
  output logic [SLOT_W-1:0]      slot
);

  logic [SECTOR_BITS-1:0] tags [CACHE_SLOTS];
  logic [CACHE_SLOTS-1:0] valid_bits;
  logic [SLOT_W-1:0]      ptr;
  logic [SLOT_W-1:0]      ptr_next;

  logic [CACHE_SLOTS-1:0] match;
  logic [SLOT_W-1:0]      hit_slot;
  logic                   hit;
  logic                   alloc;

  always_comb begin
    for (int i = 0; i < CACHE_SLOTS; i++) begin
      match[i] = valid_bits[i] && (tags[i] == sector_number);
    end
  end

  // tags stay unique, so at most one match and an or-encode is exact
  always_comb begin
    hit_slot = '0;
    for (int i = 0; i < CACHE_SLOTS; i++) begin
      if (match[i]) begin
        hit_slot = hit_slot | SLOT_W'(i);
      end
    end
  end

  assign hit   = |match;
  assign alloc = !hit && (operation == sctm_pkg::OP_READ);

  assign ptr_next = (ptr == SLOT_W'(CACHE_SLOTS - 1)) ? '0 : ptr + SLOT_W'(1);

  always_comb begin
    status.hit         = hit;
    status.fill_needed = alloc;
    if (hit) begin
      slot = hit_slot;
    end else if (alloc) begin
      slot = ptr;
    end else begin
      slot = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
      ptr        <= '0;
    end else if (commit && alloc) begin
      valid_bits[ptr] <= 1'b1;
      ptr             <= ptr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (commit && alloc) begin
      tags[ptr] <= sector_number;
    end
  end

  `SCTM_ASSERT_ALWAYS(a_single_match, clk, rst, $onehot0(match))
  `SCTM_ASSERT_ALWAYS(a_ptr_in_range, clk, rst, ptr <= SLOT_W'(CACHE_SLOTS - 1))
  `SCTM_ASSERT_NEXT(a_alloc_sets_valid, clk, rst, commit && alloc,
                    valid_bits[$past(ptr)] && tags[$past(ptr)] == $past(sector_number))

endmodule

### rtl/sector_cache_tag_manager_core.sv
// top level of the sector cache tag manager: request stage and result register
// depends on sctm_pkg, sctm_req_if, sctm_resp_if, sctm_tag_store and the macro header
//
//   channel  dir  beat contents
//   req      in   operation, sector_number
//   resp     out  hit, slot, fill_needed
//
// one beat per cycle sustained while results are taken; a taken request waits in the request
// stage, then its result is registered in the output register and taken from there as a beat
// the parallel tag compare plus pointer update between the request and result registers
// sets the cycle; reset clears the valid bits and pointer at once, no clearing pass
// a stalled result holds in the output register, and the request stage holds behind it
`include "sector_cache_tag_manager_core_macros.svh"

module sector_cache_tag_manager_core #(
  parameter int CACHE_SLOTS = sctm_pkg::DEFAULT_CACHE_SLOTS,
  parameter int SECTOR_BITS = sctm_pkg::DEFAULT_SECTOR_BITS,
  parameter int SLOT_W      = $clog2(CACHE_SLOTS)
) (
  input  logic        clk,
  input  logic        rst,
  sctm_req_if.sink    req,
  sctm_resp_if.source resp
);

  logic                   s1_valid;
  logic                   s1_op;
  logic [SECTOR_BITS-1:0] s1_sec;
  logic                   advance;

  logic                   out_valid;
  logic                   out_hit;
  logic [SLOT_W-1:0]      out_slot;
  logic                   out_fill;

  sctm_pkg::status_t      lk_status;
  logic [SLOT_W-1:0]      lk_slot;

  assign advance   = s1_valid && (!out_valid || resp.ready);
  assign req.ready = !s1_valid || advance;

  sctm_tag_store #(
    .CACHE_SLOTS (CACHE_SLOTS),
    .SECTOR_BITS (SECTOR_BITS),
    .SLOT_W      (SLOT_W)
  ) u_tags (
    .clk           (clk),
    .rst           (rst),
    .commit        (advance),
    .operation     (s1_op),
    .sector_number (s1_sec),
    .status        (lk_status),
    .slot          (lk_slot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (req.ready) begin
        s1_valid <= req.valid;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (resp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_op  <= req.operation;
      s1_sec <= req.sector_number;
    end
    if (advance) begin
      out_hit  <= lk_status.hit;
      out_slot <= lk_slot;
      out_fill <= lk_status.fill_needed;
    end
  end

  assign resp.valid       = out_valid;
  assign resp.hit         = out_hit;
  assign resp.slot        = out_slot;
  assign resp.fill_needed = out_fill;

  // request stage only waits on a full, unconsumed result register
  `SCTM_ASSERT_IMPLIES(a_stall_cause, clk, rst, s1_valid && !advance,
                       out_valid && !resp.ready)
  `SCTM_ASSERT_IMPLIES(a_hit_no_fill, clk, rst, out_valid, !(out_hit && out_fill))
  `SCTM_ASSERT_NEXT(a_advance_fills_out, clk, rst, advance, out_valid)

endmodule

### dv/tb_sector_cache_tag_manager_core.sv
`timescale 1ns / 1ps
// testbench for the sector cache tag manager: directed lookups, then random traffic
// depends on sctm_pkg, sctm_req_if, sctm_resp_if and sector_cache_tag_manager_core
module tb_sector_cache_tag_manager_core;

  localparam int SLOTS      = sctm_pkg::DEFAULT_CACHE_SLOTS;
  localparam int SECTOR_W   = sctm_pkg::DEFAULT_SECTOR_BITS;
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int MAX_SECTOR = (1 << SECTOR_W) - 1;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              fill_needed;
  } lookup_t;

  logic clk = 1'b0;
  logic rst;

  always #5 clk = ~clk;

  sctm_req_if  #(.SECTOR_BITS(SECTOR_W)) req_bus ();
  sctm_resp_if #(.CACHE_SLOTS(SLOTS))    resp_bus ();

  sector_cache_tag_manager_core #(
    .CACHE_SLOTS(SLOTS),
    .SECTOR_BITS(SECTOR_W)
  ) i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_bus.sink),
    .resp(resp_bus.source)
  );

  // shadow copy of the tag state
  logic [SECTOR_W-1:0] shadow_tag[SLOTS];
  logic                shadow_valid[SLOTS];
  logic [SLOT_W-1:0]   shadow_replace_ptr;

  lookup_t expected_lookups[$];
  int      mismatch_count = 0;
  int      cycle_count = 0;
  int      src_idle_pct = 0;
  int      sink_stall_pct = 0;

  // parallel tag compare; a read miss claims the slot under the pointer
  function automatic lookup_t lookup_sector(sctm_pkg::op_t op, logic [SECTOR_W-1:0] sector);
    lookup_t res;
    bit      found;
    res   = '0;
    found = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (!found && shadow_valid[i] && shadow_tag[i] == sector) begin
        found    = 1'b1;
        res.slot = i[SLOT_W-1:0];
      end
    end
    res.hit = found;
    if (!found && op == sctm_pkg::OP_READ) begin
      shadow_tag[shadow_replace_ptr]   = sector;
      shadow_valid[shadow_replace_ptr] = 1'b1;
      res.slot                         = shadow_replace_ptr;
      res.fill_needed                  = 1'b1;
      shadow_replace_ptr               = shadow_replace_ptr + 1'b1;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d lookups outstanding", $time, expected_lookups.size());
      $display("Verification failed");
      $finish;
    end
  end

  // result checker and sink stall generator
  always @(posedge clk) begin : result_check
    lookup_t want;
    if (rst) begin
      resp_bus.ready <= 1'b0;
    end else begin
      if (resp_bus.valid === 1'b1 && resp_bus.ready === 1'b1) begin
        if (expected_lookups.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, got hit=%0b slot=%0d fill=%0b",
                   $time, resp_bus.hit, resp_bus.slot, resp_bus.fill_needed);
          mismatch_count++;
        end else begin
          want = expected_lookups.pop_front();
          if (resp_bus.hit !== want.hit) begin
            $display("%0t: hit mismatch, expected %0b, got %0b", $time, want.hit, resp_bus.hit);
            mismatch_count++;
          end
          if (resp_bus.slot !== want.slot) begin
            $display("%0t: slot mismatch, expected %0d, got %0d", $time, want.slot,
                     resp_bus.slot);
            mismatch_count++;
          end
          if (resp_bus.fill_needed !== want.fill_needed) begin
            $display("%0t: fill_needed mismatch, expected %0b, got %0b", $time,
                     want.fill_needed, resp_bus.fill_needed);
            mismatch_count++;
          end
        end
      end
      resp_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  task automatic hold_idle();
    req_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  // one request beat; expectation is formed when the beat is taken
  task automatic send_request(sctm_pkg::op_t op, logic [SECTOR_W-1:0] sector);
    while ($urandom_range(99) < src_idle_pct) hold_idle();
    req_bus.valid         <= 1'b1;
    req_bus.operation     <= op;
    req_bus.sector_number <= sector;
    do @(posedge clk); while (req_bus.ready !== 1'b1);
    expected_lookups.push_back(lookup_sector(op, sector));
  endtask

  task automatic wait_for_drain();
    while (expected_lookups.size() != 0) hold_idle();
  endtask

  // write on an empty cache, then allocate, hit and update at both sector extremes
  task automatic test_first_lookups();
    send_request(sctm_pkg::OP_WRITE, '0);
    send_request(sctm_pkg::OP_READ, '0);
    send_request(sctm_pkg::OP_READ, '0);
    send_request(sctm_pkg::OP_WRITE, '0);
    send_request(sctm_pkg::OP_READ, SECTOR_W'(MAX_SECTOR));
    send_request(sctm_pkg::OP_WRITE, SECTOR_W'(MAX_SECTOR));
    send_request(sctm_pkg::OP_READ, SECTOR_W'(MAX_SECTOR));
  endtask

  // fill the remaining slots, wrap the pointer and evict the oldest tags
  task automatic test_wrap_and_evict();
    for (int i = 2; i < SLOTS; i++) send_request(sctm_pkg::OP_READ, SECTOR_W'(12'h800 | i));
    send_request(sctm_pkg::OP_READ, SECTOR_W'(12'haaa));
    send_request(sctm_pkg::OP_READ, '0);
    send_request(sctm_pkg::OP_WRITE, SECTOR_W'(MAX_SECTOR));
    send_request(sctm_pkg::OP_READ, SECTOR_W'(12'h555));
  endtask

  // sender holds off until every outstanding result is back
  task automatic test_drain_pause();
    for (int i = 0; i < 20; i++) begin
      send_request(sctm_pkg::OP_READ, SECTOR_W'($urandom_range(31)));
    end
    wait_for_drain();
    for (int i = 0; i < 20; i++) begin
      send_request($urandom_range(1) ? sctm_pkg::OP_WRITE : sctm_pkg::OP_READ,
                   SECTOR_W'($urandom_range(31)));
    end
    wait_for_drain();
  endtask

  // mostly a small working set so hits and evictions both occur, plus stray sectors
  task automatic test_random_traffic(int src_pct, int sink_pct, int n_items);
    logic [SECTOR_W-1:0] working_set[32];
    int                  set_size;
    sctm_pkg::op_t       op;
    logic [SECTOR_W-1:0] sector;
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    set_size       = $urandom_range(32, 8);
    foreach (working_set[k]) working_set[k] = SECTOR_W'($urandom_range(MAX_SECTOR));
    working_set[0] = '0;
    working_set[1] = SECTOR_W'(MAX_SECTOR);
    for (int i = 0; i < n_items; i++) begin
      op = ($urandom_range(99) < 30) ? sctm_pkg::OP_WRITE : sctm_pkg::OP_READ;
      if ($urandom_range(99) < 85) sector = working_set[$urandom_range(set_size - 1)];
      else sector = SECTOR_W'($urandom_range(MAX_SECTOR));
      send_request(op, sector);
    end
    wait_for_drain();
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      shadow_tag[i]   = '0;
      shadow_valid[i] = 1'b0;
    end
    shadow_replace_ptr = '0;
    rst                   <= 1'b1;
    req_bus.valid         <= 1'b0;
    req_bus.operation     <= sctm_pkg::OP_READ;
    req_bus.sector_number <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_first_lookups();
    test_wrap_and_evict();
    wait_for_drain();
    test_drain_pause();
    test_random_traffic(0, 0, 460);
    test_random_traffic(83, 0, 460);
    test_random_traffic(0, 83, 460);
    test_random_traffic(16, 16, 460);

    src_idle_pct   = 0;
    sink_stall_pct = 0;
    wait_for_drain();
    // pipeline is two deep; allow stray beats to show up
    repeat (10) @(posedge clk);
    if (expected_lookups.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_lookups.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
